// ===== design/price_indicator_engine_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the price indicator engine
// Concurrent checks clocked on a rising edge and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef PRICE_INDICATOR_ENGINE_UNIT_ASSERT_SVH
`define PRICE_INDICATOR_ENGINE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PIE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pie_pkg.sv =====
// ----------------------------------------------------------------------------
// pie_pkg
// Shared constants, codes and types of the price indicator engine.
// ----------------------------------------------------------------------------
package pie_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int RING_AW    = $clog2(WINDOW_MAX);

    localparam int PRICE_W    = 32;
    localparam int WIN_W      = 9;
    localparam int ALPHA_W    = 17;
    localparam int RSIP_W     = 8;
    localparam int BF_W       = 16;
    localparam int RSI_W      = 15;
    localparam int TOTAL_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // shared divider
    localparam int DIV_W      = 64;
    localparam int DEN_W      = 33;
    localparam int DLEN_W     = $clog2(DIV_W + 1);

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSIP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 2'd3;

    localparam logic [WIN_W-1:0]   WIN_RST   = 9'd20;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
    localparam logic [RSIP_W-1:0]  RSIP_RST  = 8'd14;
    localparam logic [BF_W-1:0]    BF_RST    = 16'd8192;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    localparam logic [RSI_W-1:0] RSI_FULL = 15'd25600;
    localparam logic [RSI_W-1:0] RSI_HALF = 15'd12800;

    localparam logic [DLEN_W-1:0] DLEN_32 = 7'd32;
    localparam logic [DLEN_W-1:0] DLEN_40 = 7'd40;
    localparam logic [DLEN_W-1:0] DLEN_48 = 7'd48;
    localparam logic [DLEN_W-1:0] DLEN_64 = 7'd64;

    typedef enum logic [4:0] {
        ST_IDLE, ST_READ, ST_SUM, ST_EMA, ST_AVG, ST_MEAN, ST_DEV, ST_SSUM,
        ST_VAR, ST_SQRT, ST_OFF, ST_GMUL, ST_GDIV, ST_GQ, ST_LMUL, ST_LDIV,
        ST_LQ, ST_RMUL, ST_RDIV, ST_RQ, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_READ, OP_SUM, OP_EMA, OP_AVG, OP_MEAN, OP_DEV,
        OP_SSUM, OP_VAR, OP_SQRT, OP_OFF, OP_GMUL, OP_GDIV, OP_GQ, OP_LMUL,
        OP_LDIV, OP_LQ, OP_RMUL, OP_RDIV, OP_RQ, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic bands;      // count reached window
        logic multi;      // at least two samples
        logic loss_zero;
    } t_status;

    typedef struct packed {
        logic [PRICE_W-1:0] moving_avg;
        logic [PRICE_W-1:0] smoothed_price;
        logic [PRICE_W-1:0] band_upper;
        logic [PRICE_W-1:0] band_lower;
        logic               bands_valid;
        logic [RSI_W-1:0]   strength_index;
        logic               strength_valid;
    } t_result;

endpackage

// ===== design/pie_in_if.sv =====
// ----------------------------------------------------------------------------
// pie_in_if
// Price input channel: valid/ready plus one price per beat.
// ----------------------------------------------------------------------------
interface pie_in_if import pie_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

// ===== design/pie_out_if.sv =====
// ----------------------------------------------------------------------------
// pie_out_if
// Result channel: valid/ready plus the indicator fields per beat.
// ----------------------------------------------------------------------------
interface pie_out_if import pie_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] moving_avg;
    logic [PRICE_W-1:0] smoothed_price;
    logic [PRICE_W-1:0] band_upper;
    logic [PRICE_W-1:0] band_lower;
    logic               bands_valid;
    logic [RSI_W-1:0]   strength_index;
    logic               strength_valid;

    modport source (output valid, output moving_avg, output smoothed_price,
                    output band_upper, output band_lower, output bands_valid,
                    output strength_index, output strength_valid, input ready);
    modport sink   (input valid, input moving_avg, input smoothed_price,
                    input band_upper, input band_lower, input bands_valid,
                    input strength_index, input strength_valid, output ready);
endinterface

// ===== design/pie_ram.sv =====
// ----------------------------------------------------------------------------
// pie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pie_div.sv =====
// ----------------------------------------------------------------------------
// pie_div
// Restoring divider, one quotient bit per cycle, dividend length per request.
// ----------------------------------------------------------------------------
module pie_div import pie_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [DEN_W-1:0]  i_divisor,
    input  logic [DLEN_W-1:0] i_len,
    output logic [DIV_W-1:0]  o_quot,
    output logic              o_busy
);

    logic [DLEN_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    sh;
    logic              ge;

    assign sh = {r_rem, r_dvd[DIV_W-1]};
    assign ge = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_len;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // left-align the significant bits of the dividend
            r_dvd <= i_dividend << (DLEN_W'(DIV_W) - i_len);
            r_den <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem <= ge ? DEN_W'(sh - {1'b0, r_den}) : sh[DEN_W-1:0];
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_quot = r_q;
    assign o_busy = (r_cnt != '0);

endmodule

// ===== design/pie_sqrt.sv =====
// ----------------------------------------------------------------------------
// pie_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pie_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic [31:0] o_root,
    output logic        o_busy
);

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= 64'd1 << 62;
        end else if (r_bit != '0) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (r_v >= trial) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_root = r_res[31:0];
    assign o_busy = (r_bit != '0);

endmodule

// ===== design/pie_ctrl.sv =====
// ----------------------------------------------------------------------------
// pie_ctrl
// Sequencer: walks one price through the datapath steps, owns handshakes.
// ----------------------------------------------------------------------------
module pie_ctrl import pie_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_load;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_READ;
            ST_READ: n_state = ST_SUM;
            ST_SUM:  n_state = ST_EMA;
            ST_EMA:  n_state = ST_AVG;
            ST_AVG:  if (!i_status.div_busy) n_state = ST_MEAN;
            ST_MEAN: if (!i_status.div_busy) n_state = ST_DEV;
            ST_DEV:  n_state = ST_SSUM;
            ST_SSUM: begin
                if (i_status.bands)      n_state = ST_VAR;
                else if (i_status.multi) n_state = ST_GMUL;
                else                     n_state = ST_OUT;
            end
            ST_VAR:  if (!i_status.div_busy) n_state = ST_SQRT;
            ST_SQRT: if (!i_status.sqrt_busy) n_state = ST_OFF;
            ST_OFF:  n_state = i_status.multi ? ST_GMUL : ST_OUT;
            ST_GMUL: n_state = ST_GDIV;
            ST_GDIV: n_state = ST_GQ;
            ST_GQ:   if (!i_status.div_busy) n_state = ST_LMUL;
            ST_LMUL: n_state = ST_LDIV;
            ST_LDIV: n_state = ST_LQ;
            ST_LQ:   if (!i_status.div_busy) n_state = ST_RMUL;
            ST_RMUL: n_state = ST_RDIV;
            ST_RDIV: n_state = i_status.loss_zero ? ST_OUT : ST_RQ;
            ST_RQ:   if (!i_status.div_busy) n_state = ST_OUT;
            ST_OUT:  if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: o_cmd.op = accept ? OP_ACCEPT : OP_NONE;
            ST_READ: o_cmd.op = OP_READ;
            ST_SUM:  o_cmd.op = OP_SUM;
            ST_EMA:  o_cmd.op = OP_EMA;
            ST_AVG:  o_cmd.op = OP_AVG;
            ST_MEAN: o_cmd.op = OP_MEAN;
            ST_DEV:  o_cmd.op = OP_DEV;
            ST_SSUM: o_cmd.op = OP_SSUM;
            ST_VAR:  o_cmd.op = OP_VAR;
            ST_SQRT: o_cmd.op = OP_SQRT;
            ST_OFF:  o_cmd.op = OP_OFF;
            ST_GMUL: o_cmd.op = OP_GMUL;
            ST_GDIV: o_cmd.op = OP_GDIV;
            ST_GQ:   o_cmd.op = OP_GQ;
            ST_LMUL: o_cmd.op = OP_LMUL;
            ST_LDIV: o_cmd.op = OP_LDIV;
            ST_LQ:   o_cmd.op = OP_LQ;
            ST_RMUL: o_cmd.op = OP_RMUL;
            ST_RDIV: o_cmd.op = OP_RDIV;
            ST_RQ:   o_cmd.op = OP_RQ;
            ST_OUT:  o_cmd.op = out_load ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== design/pie_dp.sv =====
// ----------------------------------------------------------------------------
// pie_dp
// Datapath: config, indicator state, price ring, shared multiplier, divider
// and square root.
// ----------------------------------------------------------------------------
module pie_dp import pie_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PRICE_W-1:0]    i_price,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output t_result               o_result
);

    localparam int RA1 = RING_AW + 1;

    // configuration
    logic [WIN_W-1:0]   r_win;
    logic [ALPHA_W-1:0] r_alpha;
    logic [RSIP_W-1:0]  r_rsip;
    logic [BF_W-1:0]    r_bf;
    logic [WIN_W-1:0]   w_eff;
    logic [ALPHA_W-1:0] a_eff;
    logic [RSIP_W-1:0]  p_eff;

    // indicator state
    logic [RING_AW-1:0] r_ptr;
    logic [TOTAL_W-1:0] r_total;
    logic [31:0]        r_count;
    logic [31:0]        r_ema, r_mean, r_gain, r_loss, r_last;
    logic [63:0]        r_ssum;

    // per-item working registers
    logic [31:0]        r_price, r_avg, r_dmag, r_upper, r_lower;
    logic               r_neg;
    logic [RSI_W-1:0]   r_rsi;
    logic [63:0]        r_acc, r_prod;
    t_result            r_out;

    logic               past_win, bands, multi;
    logic [RA1-1:0]     rsum;
    logic [RING_AW-1:0] raddr;
    logic [31:0]        old;
    logic [TOTAL_W:0]   tsum;
    logic [TOTAL_W-1:0] tsat, tnext;
    logic               neg;
    logic [31:0]        dmag, d2mag, g, l;
    logic [64:0]        ssum_wide;
    logic [63:0]        ssum_next, off, up;
    logic [32:0]        tot;

    logic [31:0]        mul_a, mul_b;
    logic               div_start, div_busy;
    logic [DIV_W-1:0]   div_dvd, div_q;
    logic [DEN_W-1:0]   div_den;
    logic [DLEN_W-1:0]  div_len;
    logic               sq_start, sq_busy;
    logic [63:0]        sq_val;
    logic [31:0]        sq_root;

    // clamp config to its meaningful range
    always_comb begin
        if (r_win == '0)                      w_eff = WIN_W'(1);
        else if (r_win > WIN_W'(WINDOW_MAX))  w_eff = WIN_W'(WINDOW_MAX);
        else                                  w_eff = r_win;
        a_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
        p_eff = (r_rsip == '0) ? RSIP_W'(1) : r_rsip;
    end

    assign past_win = (r_count > 32'(w_eff));
    assign bands    = (r_count >= 32'(w_eff));
    assign multi    = (r_count > 32'd1);

    // ring slot one window back
    always_comb begin
        rsum = {1'b0, r_ptr} + RA1'(WINDOW_MAX) - RA1'(w_eff);
        if (rsum >= RA1'(WINDOW_MAX)) rsum = rsum - RA1'(WINDOW_MAX);
        raddr = rsum[RING_AW-1:0];
    end

    pie_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_MAX)) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_SUM),
        .i_waddr (r_ptr),
        .i_wdata (r_price),
        .i_raddr (raddr),
        .o_rdata (old)
    );

    always_comb begin
        tsum  = {1'b0, r_total} + (TOTAL_W + 1)'(r_price);
        tsat  = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
        tnext = tsat;
        if (past_win) tnext = (tsat >= TOTAL_W'(old)) ? tsat - TOTAL_W'(old) : '0;
    end

    assign neg   = (r_price < r_mean);
    assign dmag  = neg ? r_mean - r_price : r_price - r_mean;
    assign d2mag = r_neg ? r_mean - r_price : r_price - r_mean;
    assign g     = (r_price > r_last) ? r_price - r_last : '0;
    assign l     = (r_price > r_last) ? '0 : r_last - r_price;
    assign tot   = {1'b0, r_gain} + {1'b0, r_loss};

    assign ssum_wide = {1'b0, r_ssum} + {1'b0, r_prod};
    assign ssum_next = ssum_wide[64] ? '1 : ssum_wide[63:0];

    assign off = (r_prod + 64'd2048) >> 12;
    assign up  = 64'(r_mean) + off;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_READ: begin
                mul_a = 32'(ALPHA_ONE - a_eff);
                mul_b = (r_count == 32'd1) ? r_price : r_ema;
            end
            OP_SUM: begin
                mul_a = 32'(a_eff);
                mul_b = r_price;
            end
            OP_DEV: begin
                mul_a = r_dmag;
                mul_b = d2mag;
            end
            OP_SQRT: begin
                mul_a = 32'(r_bf);
                mul_b = sq_root;
            end
            OP_GMUL: begin
                mul_a = r_gain;
                mul_b = 32'(p_eff - 1'b1);
            end
            OP_LMUL: begin
                mul_a = r_loss;
                mul_b = 32'(p_eff - 1'b1);
            end
            OP_RMUL: begin
                mul_a = 32'(RSI_FULL);
                mul_b = r_gain;
            end
            default: ;
        endcase
    end

    // divider and square-root requests
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_den   = '0;
        div_len   = DLEN_64;
        sq_start  = 1'b0;
        sq_val    = '0;
        case (i_cmd.op)
            OP_EMA: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(r_total);
                div_den   = past_win ? DEN_W'(w_eff) : DEN_W'(r_count);
                div_len   = DLEN_40;
            end
            OP_AVG: begin
                div_start = !div_busy;
                div_dvd   = DIV_W'(dmag);
                div_den   = DEN_W'(r_count);
                div_len   = DLEN_32;
            end
            OP_SSUM: begin
                div_start = bands && multi;
                div_dvd   = ssum_next;
                div_den   = DEN_W'(r_count - 32'd1);
                div_len   = DLEN_64;
            end
            OP_VAR: begin
                sq_start  = !div_busy;
                sq_val    = multi ? div_q : '0;
            end
            OP_GDIV: begin
                div_start = 1'b1;
                div_dvd   = r_prod + 64'(g);
                div_den   = DEN_W'(p_eff);
                div_len   = DLEN_40;
            end
            OP_LDIV: begin
                div_start = 1'b1;
                div_dvd   = r_prod + 64'(l);
                div_den   = DEN_W'(p_eff);
                div_len   = DLEN_40;
            end
            OP_RDIV: begin
                div_start = (r_loss != '0);
                div_dvd   = r_prod + 64'(tot[32:1]);
                div_den   = tot;
                div_len   = DLEN_48;
            end
            default: ;
        endcase
    end

    pie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_den),
        .i_len      (div_len),
        .o_quot     (div_q),
        .o_busy     (div_busy)
    );

    pie_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_val),
        .o_root  (sq_root),
        .o_busy  (sq_busy)
    );

    // config and indicator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= WIN_RST;
            r_alpha <= ALPHA_RST;
            r_rsip  <= RSIP_RST;
            r_bf    <= BF_RST;
            r_ptr   <= '0;
            r_total <= '0;
            r_count <= '0;
            r_ema   <= '0;
            r_mean  <= '0;
            r_ssum  <= '0;
            r_gain  <= '0;
            r_loss  <= '0;
            r_last  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: r_win   <= i_cfg_data[WIN_W-1:0];
                    CFG_ALPHA:  r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    CFG_RSIP:   r_rsip  <= i_cfg_data[RSIP_W-1:0];
                    CFG_BAND:   r_bf    <= i_cfg_data[BF_W-1:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_ACCEPT: if (r_count != '1) r_count <= r_count + 32'd1;
                OP_SUM: begin
                    r_total <= tnext;
                    r_ptr   <= (r_ptr == RING_AW'(WINDOW_MAX - 1)) ? '0 : r_ptr + 1'b1;
                end
                OP_EMA:  r_ema <= 32'((r_acc + r_prod + 64'd32768) >> 16);
                OP_MEAN: begin
                    if (!div_busy) begin
                        r_mean <= r_neg ? r_mean - div_q[31:0] : r_mean + div_q[31:0];
                    end
                end
                OP_SSUM: r_ssum <= ssum_next;
                OP_GQ:   if (!div_busy) r_gain <= div_q[31:0];
                OP_LQ:   if (!div_busy) r_loss <= div_q[31:0];
                OP_OUT:  r_last <= r_price;
                default: ;
            endcase
        end
    end

    // per-item working values and result register
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_price <= i_price;
                r_upper <= '0;
                r_lower <= '0;
                r_rsi   <= '0;
            end
            OP_SUM: r_acc <= r_prod;
            OP_AVG: begin
                if (!div_busy) begin
                    r_avg  <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
                    r_neg  <= neg;
                    r_dmag <= dmag;
                end
            end
            OP_OFF: begin
                r_upper <= (up[63:32] != '0) ? '1 : up[31:0];
                r_lower <= (off >= 64'(r_mean)) ? '0 : r_mean - off[31:0];
            end
            OP_RDIV: begin
                if (r_loss == '0) r_rsi <= (r_gain == '0) ? RSI_HALF : RSI_FULL;
            end
            OP_RQ: if (!div_busy) r_rsi <= div_q[RSI_W-1:0];
            OP_OUT: begin
                r_out.moving_avg     <= r_avg;
                r_out.smoothed_price <= r_ema;
                r_out.band_upper     <= r_upper;
                r_out.band_lower     <= r_lower;
                r_out.bands_valid    <= bands;
                r_out.strength_index <= r_rsi;
                r_out.strength_valid <= multi;
            end
            default: ;
        endcase
    end

    assign o_status.div_busy  = div_busy;
    assign o_status.sqrt_busy = sq_busy;
    assign o_status.bands     = bands;
    assign o_status.multi     = multi;
    assign o_status.loss_zero = (r_loss == '0);
    assign o_result           = r_out;

endmodule

// ===== design/price_indicator_engine_unit.sv =====
// ----------------------------------------------------------------------------
// price_indicator_engine_unit
// Market indicators per price tick: SMA, EMA, Bollinger bands and Wilder RSI.
// ----------------------------------------------------------------------------
// Usage:
//  - i_price_ch carries one Q16.16 price per beat; o_result_ch returns exactly
//    one result beat per price, in order.
//  - Config is a write-only port (i_cfg_we/i_cfg_index/i_cfg_data); index 0
//    window length, 1 EMA alpha, 2 RSI period, 3 band factor. Write only while
//    no price is in flight.
//  - One price is worked at a time; the next price is taken the cycle after
//    the result is loaded. The time from accept to result is set by the
//    shared one-bit-per-cycle divider (up to six divides of 32 to 64 bits)
//    plus a 32-step square root, and grows once bands and RSI are live.
//  - The result sits in an output register; a stalled receiver holds the next
//    result at the sequencer's last step, with the input not ready meanwhile.
//  - Reset (synchronous, active low) clears all indicator state and loads the
//    default config. The price ring is not cleared: a slot is only read
//    after it was written.
// ----------------------------------------------------------------------------
module price_indicator_engine_unit import pie_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pie_in_if.sink                i_price_ch,
    pie_out_if.source             o_result_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    // sequencer: steps, input accept and output valid
    pie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_price_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic, state and the price ring
    pie_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_price     (i_price_ch.price),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    assign i_price_ch.ready           = in_ready;
    assign o_result_ch.valid          = out_valid;
    assign o_result_ch.moving_avg     = result.moving_avg;
    assign o_result_ch.smoothed_price = result.smoothed_price;
    assign o_result_ch.band_upper     = result.band_upper;
    assign o_result_ch.band_lower     = result.band_lower;
    assign o_result_ch.bands_valid    = result.bands_valid;
    assign o_result_ch.strength_index = result.strength_index;
    assign o_result_ch.strength_valid = result.strength_valid;

endmodule

// ===== design/pie_chk.sv =====
// ----------------------------------------------------------------------------
// pie_chk
// Port-level checks of the price indicator engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "price_indicator_engine_unit_assert.svh"

module pie_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_moving_avg,
    input logic [31:0] i_smoothed_price,
    input logic [31:0] i_band_upper,
    input logic [31:0] i_band_lower,
    input logic        i_bands_valid,
    input logic [14:0] i_strength_index,
    input logic        i_strength_valid
);

    // one price in flight: a taken beat closes the input
    `PIE_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "price taken while busy")
    // stalled result holds
    `PIE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_moving_avg) && $stable(i_smoothed_price) && $stable(i_band_upper) && $stable(i_band_lower) && $stable(i_strength_index), "stalled result changed")
    `PIE_ASSERT_NOW(a_band_gate, i_clk, i_rst_n, i_out_valid && !i_bands_valid, i_band_upper == 32'd0 && i_band_lower == 32'd0, "bands nonzero while not valid")
    `PIE_ASSERT_NOW(a_rsi_gate, i_clk, i_rst_n, i_out_valid && !i_strength_valid, i_strength_index == 15'd0, "RSI nonzero while not valid")
    `PIE_ASSERT_NOW(a_band_order, i_clk, i_rst_n, i_out_valid, i_band_lower <= i_band_upper && i_strength_index <= 15'd25600, "band order or RSI range broken")

endmodule

bind price_indicator_engine_unit pie_chk u_pie_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_price_ch.valid),
    .i_in_ready       (i_price_ch.ready),
    .i_out_valid      (o_result_ch.valid),
    .i_out_ready      (o_result_ch.ready),
    .i_moving_avg     (o_result_ch.moving_avg),
    .i_smoothed_price (o_result_ch.smoothed_price),
    .i_band_upper     (o_result_ch.band_upper),
    .i_band_lower     (o_result_ch.band_lower),
    .i_bands_valid    (o_result_ch.bands_valid),
    .i_strength_index (o_result_ch.strength_index),
    .i_strength_valid (o_result_ch.strength_valid)
);

// ===== verif/tb_price_indicator_engine_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_price_indicator_engine_unit
// Self-checking bench for the price indicator engine: directed ticks, then
// random price walks under several register settings, each result checked
// against a typed-in beat or a cycle-free model of the indicators.
// ----------------------------------------------------------------------------
module tb_price_indicator_engine_unit import pie_pkg::*; ();

    localparam int  CLK_HALF   = 4;
    localparam int  RAND_TICKS = 1225;
    localparam int  N_PHASES   = 9;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint TOTAL_SAT   = 64'hFF_FFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pie_in_if  price_ch ();
    pie_out_if result_ch ();

    price_indicator_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_price_ch  (price_ch.sink),
        .o_result_ch (result_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Indicator model state (mirrors the engine's registers)
    // ------------------------------------------------------------------
    logic [WIN_W-1:0]   m_window;
    logic [ALPHA_W-1:0] m_alpha;
    logic [RSIP_W-1:0]  m_rsi_len;
    logic [BF_W-1:0]    m_band_fac;

    logic [31:0] m_ring [WINDOW_MAX];
    logic [7:0]  m_ptr;
    logic [63:0] m_total;
    logic [31:0] m_count;
    logic [31:0] m_ema;
    logic [31:0] m_mean;
    logic [63:0] m_sqdev;
    logic [31:0] m_gain;
    logic [31:0] m_loss;
    logic [31:0] m_last;

    t_result pending_results[$];
    int      fail_count;
    longint  cycle_count;
    bit      calm;          // no idling on either side during this phase

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] smooth_wilder(logic [31:0] avg, logic [31:0] mv,
                                                  logic [31:0] per);
        logic [63:0] acc;
        acc = 64'(avg) * 64'(per - 1) + 64'(mv);
        return 32'(acc / 64'(per));
    endfunction

    function automatic void model_reset();
        m_window   = WIN_RST;
        m_alpha    = ALPHA_RST;
        m_rsi_len  = RSIP_RST;
        m_band_fac = BF_RST;
        foreach (m_ring[i]) m_ring[i] = '0;
        m_ptr = 0; m_total = 0; m_count = 0; m_ema = 0; m_mean = 0;
        m_sqdev = 0; m_gain = 0; m_loss = 0; m_last = 0;
    endfunction

    // Advances the model by one tick and returns the indicator beat.
    function automatic t_result compute_indicators(logic [31:0] price);
        logic [31:0] w, a, per, n, old, newmean, g, l;
        logic [63:0] q, dmag, d2mag, prod, stp, var_q, sd, off, up, tot;
        logic        neg;
        t_result     r;
        w   = 32'(m_window);
        a   = 32'(m_alpha);
        per = 32'(m_rsi_len);
        r   = '0;
        if (w == 0) w = 1;
        if (w > WINDOW_MAX) w = WINDOW_MAX;
        if (a > 65536) a = 65536;
        if (per == 0) per = 1;

        if (m_count != 32'hFFFF_FFFF) m_count = m_count + 1;
        n = m_count;

        // SMA over the ring; total is not rebuilt on a window change
        old = m_ring[(int'(m_ptr) + WINDOW_MAX - int'(w)) % WINDOW_MAX];
        m_ring[m_ptr] = price;
        m_ptr   = m_ptr + 1;
        m_total = m_total + 64'(price);
        if (m_total > TOTAL_SAT) m_total = TOTAL_SAT;
        if (n > w) m_total = (m_total >= 64'(old)) ? m_total - 64'(old) : 64'd0;
        q = m_total / 64'((n > w) ? w : n);
        r.moving_avg = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];

        // EMA, seeded by the first price
        if (n == 1) m_ema = price;
        m_ema = 32'((64'(65536 - a) * 64'(m_ema) + 64'(a) * 64'(price) + 64'd32768) >> 16);
        r.smoothed_price = m_ema;

        // Welford mean / squared deviation sum
        neg     = price < m_mean;
        dmag    = neg ? 64'(m_mean - price) : 64'(price - m_mean);
        stp     = dmag / 64'(n);
        newmean = neg ? m_mean - stp[31:0] : m_mean + stp[31:0];
        d2mag   = neg ? 64'(newmean - price) : 64'(price - newmean);
        m_mean  = newmean;
        prod    = dmag * d2mag;
        m_sqdev = (m_sqdev > ~prod) ? '1 : m_sqdev + prod;

        if (n >= w) begin
            var_q = (n > 1) ? m_sqdev / 64'(n - 1) : 64'd0;
            sd    = int_sqrt(var_q);
            off   = (64'(m_band_fac) * sd + 64'd2048) >> 12;
            up    = 64'(m_mean) + off;
            r.band_upper  = (up > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : up[31:0];
            r.band_lower  = (off >= 64'(m_mean)) ? 32'd0 : m_mean - off[31:0];
            r.bands_valid = 1'b1;
        end

        // Wilder RSI; a flat tick is a zero loss
        if (n > 1) begin
            g      = (price > m_last) ? price - m_last : 32'd0;
            l      = (price > m_last) ? 32'd0 : m_last - price;
            m_gain = smooth_wilder(m_gain, g, per);
            m_loss = smooth_wilder(m_loss, l, per);
            tot    = 64'(m_gain) + 64'(m_loss);
            if (m_loss == 0)
                r.strength_index = (m_gain == 0) ? RSI_HALF : RSI_FULL;
            else
                r.strength_index = RSI_W'((64'(RSI_FULL) * 64'(m_gain) + tot / 2) / tot);
            r.strength_valid = 1'b1;
        end
        m_last = price;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // Idle length: mostly short, now and then long; none in calm phases
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, checks each beat against the oldest entry
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected beat", result_ch.moving_avg, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (result_ch.moving_avg !== want.moving_avg)
                        report("moving_avg", result_ch.moving_avg, want.moving_avg);
                    if (result_ch.smoothed_price !== want.smoothed_price)
                        report("smoothed_price", result_ch.smoothed_price,
                               want.smoothed_price);
                    if (result_ch.band_upper !== want.band_upper)
                        report("band_upper", result_ch.band_upper, want.band_upper);
                    if (result_ch.band_lower !== want.band_lower)
                        report("band_lower", result_ch.band_lower, want.band_lower);
                    if (result_ch.bands_valid !== want.bands_valid)
                        report("bands_valid", 32'(result_ch.bands_valid),
                               32'(want.bands_valid));
                    if (result_ch.strength_index !== want.strength_index)
                        report("strength_index", 32'(result_ch.strength_index),
                               32'(want.strength_index));
                    if (result_ch.strength_valid !== want.strength_valid)
                        report("strength_valid", 32'(result_ch.strength_valid),
                               32'(want.strength_valid));
                end
            end
            // ready pattern: a stall run, then one ready cycle, then maybe another stall
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left      <= stall_left - 1;
            end else begin
                result_ch.ready <= 1'b1;
                stall_left      <= idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Price side
    // ------------------------------------------------------------------
    // Sends one tick; valid stays up into the next tick when no gap follows.
    task automatic send_tick(logic [31:0] price, bit typed, t_result typed_exp);
        t_result pred;
        int gap;
        price_ch.valid <= 1'b1;
        price_ch.price <= price;
        do @(posedge i_clk); while (!price_ch.ready);
        pred = compute_indicators(price);
        pending_results.push_back(typed ? typed_exp : pred);
        gap = idle_len();
        if (gap > 0) begin
            price_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits out every result, then the tail of the sequencer.
    task automatic drain();
        price_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_WINDOW: m_window   = val[WIN_W-1:0];
            CFG_ALPHA:  m_alpha    = val;
            CFG_RSIP:   m_rsi_len  = val[RSIP_W-1:0];
            CFG_BAND:   m_band_fac = val[BF_W-1:0];
            default: ;
        endcase
    endtask

    // Directed rows: price, whether the beat is typed in, and that beat
    typedef struct {
        logic [31:0] price;
        bit          typed;
        t_result     exp_beat;
    } t_tick_row;

    t_tick_row tick_table[$];

    // Register settings per random phase; extremes and out-of-range values included
    logic [CFG_DATA_W-1:0] ph_window [N_PHASES] = '{17'd1, 17'd256, 17'd0, 17'd300,
                                                   17'd511, 17'd5, 17'd2, 17'd64,
                                                   17'd20};
    logic [CFG_DATA_W-1:0] ph_alpha  [N_PHASES] = '{17'd0, 17'd65536, 17'd131071, 17'd1,
                                                   17'd32768, 17'd70000, 17'd6554,
                                                   17'd65535, 17'd100};
    logic [CFG_DATA_W-1:0] ph_rsi    [N_PHASES] = '{17'd1, 17'd255, 17'd0, 17'd2, 17'd14,
                                                   17'd3, 17'd200, 17'd7, 17'd1};
    logic [CFG_DATA_W-1:0] ph_band   [N_PHASES] = '{17'd0, 17'd65535, 17'd4096, 17'd8192,
                                                   17'd1, 17'd40000, 17'd12288,
                                                   17'd65535, 17'd0};

    initial begin
        t_tick_row   row;
        logic [31:0] level, px;
        int          mode, step;
        int          per_phase;

        fail_count  = 0;
        cycle_count = 0;
        calm        = 1'b0;
        model_reset();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_WINDOW;
        i_cfg_data      = '0;
        price_ch.valid  = 1'b0;
        price_ch.price  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: reset settings (window 20) -----------------------
        // first tick: SMA and EMA equal the price, bands and RSI not live
        row = '{32'h0001_0000, 1'b1, '{32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 0}};
        tick_table.push_back(row);
        // flat second tick: no gain, no loss, RSI sits at 50
        row = '{32'h0001_0000, 1'b1, '{32'h0001_0000, 32'h0001_0000, 0, 0, 0, RSI_HALF, 1}};
        tick_table.push_back(row);
        row.typed = 1'b0;
        foreach (ph_band[i]) begin
            // rising run, then price extremes
            row.price = 32'h0001_0000 + 32'(i) * 32'h0000_8000;
            tick_table.push_back(row);
        end
        row.price = 32'hFFFF_FFFF; tick_table.push_back(row);
        row.price = 32'h0000_0000; tick_table.push_back(row);
        row.price = 32'hFFFF_FFFF; tick_table.push_back(row);
        row.price = 32'hFFFF_FFFF; tick_table.push_back(row);
        row.price = 32'h8000_0000; tick_table.push_back(row);
        row.price = 32'h7FFF_FFFF; tick_table.push_back(row);
        row.price = 32'h5555_5555; tick_table.push_back(row);
        row.price = 32'hAAAA_AAAA; tick_table.push_back(row);
        row.price = 32'h0000_0001; tick_table.push_back(row);
        row.price = 32'h0000_0000; tick_table.push_back(row);
        row.price = 32'h0000_0000; tick_table.push_back(row);
        foreach (tick_table[i])
            send_tick(tick_table[i].price, tick_table[i].typed, tick_table[i].exp_beat);

        // --- random phases: drain, rewrite all registers, random walk ----
        per_phase = RAND_TICKS / N_PHASES;
        level     = $urandom;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            // engine must be idle before a register write
            drain();
            write_reg(CFG_WINDOW, ph_window[ph]);
            write_reg(CFG_ALPHA,  ph_alpha[ph]);
            write_reg(CFG_RSIP,   ph_rsi[ph]);
            write_reg(CFG_BAND,   ph_band[ph]);
            calm = (ph % 4 == 3);
            for (int k = 0; k < per_phase; k++) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) begin
                    px = $urandom;               // full-range noise
                end else if (mode == 1) begin
                    px = $urandom_range(0, 255); // near the floor
                end else begin
                    // market-like walk around the current level
                    step  = $urandom_range(0, 8192) - 4096;
                    level = level + 32'(step);
                    px    = level;
                end
                send_tick(px, 1'b0, '0);
            end
        end

        // --- wind-down ----------------------------------------------------
        price_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
